/* src/pie_pkg.sv */
// Shared constants, types and helpers for the packed index extractor.
package pie_pkg;

  localparam int MAX_FIELD_BITS = 12;
  localparam int STORE_WORDS    = 768;
  localparam int STORE_AW       = $clog2(STORE_WORDS);
  localparam int WIDTH_W        = $clog2(MAX_FIELD_BITS + 1);
  localparam int CELL_W         = 12;
  localparam int POS_W          = CELL_W + WIDTH_W;
  localparam int WORD_W         = POS_W - 6;
  localparam int ENTRIES_W      = 13;
  localparam int LOADED_W       = 10;
  localparam int ADDR_IN_W      = 10;
  localparam int INDEX_W        = 12;
  localparam int PADDR_W        = 3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic REG_PALETTE_ENTRIES = 1'b0;
  localparam logic REG_LOADED_WORDS    = 1'b1;

  typedef struct packed {
    logic [ENTRIES_W-1:0] palette_entries;
    logic [LOADED_W-1:0]  loaded_words;
    logic [WIDTH_W-1:0]   field_width;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         off;
    logic [WIDTH_W-1:0] width;
    logic               empty;
    logic               hi_ok;
  } lookup_t;

  // max(4, ceil(log2(entries))), saturated at MAX_FIELD_BITS
  function automatic logic [WIDTH_W-1:0] field_width(input logic [ENTRIES_W-1:0] entries);
    logic [ENTRIES_W-1:0] top;
    int w;
    top = entries - ENTRIES_W'(1);
    w = 4;
    if (entries > ENTRIES_W'(16)) begin
      w = 0;
      for (int i = 0; i < ENTRIES_W; i++) begin
        if (top[i]) begin
          w = i + 1;
        end
      end
    end
    if (w > MAX_FIELD_BITS) begin
      w = MAX_FIELD_BITS;
    end
    return WIDTH_W'(w);
  endfunction

endpackage

/* src/pie_cfg.sv */
// APB register file: palette size, loaded word count and derived field width.
module pie_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pie_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output pie_pkg::cfg_t               cfg
);
  import pie_pkg::*;

  logic [ENTRIES_W-1:0] entries_r, entries_nxt;
  logic [LOADED_W-1:0]  loaded_r, loaded_nxt;
  logic [WIDTH_W-1:0]   width_r, width_nxt;
  logic                 wr_en;
  logic                 reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    entries_nxt = entries_r;
    loaded_nxt  = loaded_r;
    width_nxt   = width_r;
    if (wr_en) begin
      case (reg_sel)
        REG_PALETTE_ENTRIES: begin
          entries_nxt = cfg_pwdata[ENTRIES_W-1:0];
          width_nxt   = field_width(cfg_pwdata[ENTRIES_W-1:0]);
        end
        REG_LOADED_WORDS: begin
          loaded_nxt = cfg_pwdata[LOADED_W-1:0];
        end
        default: begin
          entries_nxt = entries_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
      loaded_r  <= '0;
      width_r   <= WIDTH_W'(4);
    end else begin
      entries_r <= entries_nxt;
      loaded_r  <= loaded_nxt;
      width_r   <= width_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PALETTE_ENTRIES: cfg_prdata = 32'(entries_r);
      REG_LOADED_WORDS:    cfg_prdata = 32'(loaded_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign cfg.palette_entries = entries_r;
  assign cfg.loaded_words    = loaded_r;
  assign cfg.field_width     = width_r;

endmodule

/* src/pie_store.sv */
// Packed word store: one write port, two registered read ports.
module pie_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [pie_pkg::STORE_AW-1:0] wr_addr,
  input  logic [63:0]                  wr_data,
  input  logic                         rd_en,
  input  logic [pie_pkg::STORE_AW-1:0] rd_addr0,
  input  logic [pie_pkg::STORE_AW-1:0] rd_addr1,
  output logic [63:0]                  rd_data0,
  output logic [63:0]                  rd_data1
);
  import pie_pkg::*;

  logic [63:0] store_r [STORE_WORDS];
  logic [63:0] rdata0_r;
  logic [63:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata0_r <= store_r[rd_addr0];
      rdata1_r <= store_r[rd_addr1];
    end
  end

  assign rd_data0 = rdata0_r;
  assign rd_data1 = rdata1_r;

endmodule

/* src/pie_extract.sv */
// Field extraction from two words, empty checks and the output register.
module pie_extract (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             s1_valid,
  input  pie_pkg::lookup_t                 s1_info,
  input  logic [63:0]                      word_lo,
  input  logic [63:0]                      word_hi,
  input  logic [pie_pkg::ENTRIES_W-1:0]    palette_entries,
  output logic                             s1_take,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pie_pkg::INDEX_W-1:0]      out_palette_index,
  output logic                             out_is_empty
);
  import pie_pkg::*;

  logic                      out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]        index_r;
  logic                      empty_r;
  logic [127:0]              pair;
  logic [127:0]              shifted;
  logic [MAX_FIELD_BITS-1:0] field;
  logic [31:0]               field_ext;
  logic                      empty;

  assign s1_take = !out_valid_r || out_ready;

  // high word contributes only when it is loaded and inside the store
  assign pair    = {(s1_info.hi_ok ? word_hi : 64'd0), word_lo};
  assign shifted = pair >> s1_info.off;

  always_comb begin
    for (int i = 0; i < MAX_FIELD_BITS; i++) begin
      field[i] = shifted[i] & (i < int'(s1_info.width));
    end
  end

  assign field_ext = 32'(field);
  assign empty = s1_info.empty || (field_ext == 32'd0)
              || (field_ext >= 32'(palette_entries));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_take) begin
      out_valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_valid) begin
      empty_r <= empty;
      index_r <= empty ? '0 : field_ext[INDEX_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = index_r;
  assign out_is_empty      = empty_r;

endmodule

/* src/packed_index_extract.sv */
// Top level: packed index array lookup from a loaded word store.
//
//  channel   direction  handshake                 payload
//  in_       input      in_valid / in_ready       operation, word_addr, word_value, cell_x/y/z
//  out_      output     out_valid / out_ready     palette_index, is_empty
//  cfg_      input      APB psel/penable/pready   palette_entries (0x0), loaded_words (0x4)
//
// One item per cycle while in_ready is high. A lookup passes address
// computation and the two-port store read, then field extraction into the
// output register. A word write finishes at its transfer and gives no result.
// Reset clears the config registers and pipeline valids; the store needs no clearing.
// Under output backpressure one lookup waits behind the output register, after
// which in_ready drops.
module packed_index_extract (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [pie_pkg::ADDR_IN_W-1:0] in_word_addr,
  input  logic [63:0]                   in_word_value,
  input  logic [3:0]                    in_cell_x,
  input  logic [3:0]                    in_cell_y,
  input  logic [3:0]                    in_cell_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pie_pkg::INDEX_W-1:0]   out_palette_index,
  output logic                          out_is_empty,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [pie_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import pie_pkg::*;

  cfg_t                 cfg;
  logic                 in_xfer;
  logic                 wr_xfer;
  logic                 lk_xfer;
  logic                 wr_in_range;
  logic [CELL_W-1:0]    cell_num;
  logic [POS_W-1:0]     pos;
  logic [WORD_W-1:0]    word;
  logic [WORD_W:0]      word_next;
  logic                 lo_ok;
  logic                 hi_ok;
  logic [STORE_AW-1:0]  rd_addr0;
  logic [STORE_AW-1:0]  rd_addr1;
  logic [63:0]          word_lo;
  logic [63:0]          word_hi;
  logic                 s1_valid_r, s1_valid_nxt;
  lookup_t              s1_r;
  lookup_t              s0_info;
  logic                 s1_take;

  pie_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign in_ready = !s1_valid_r || s1_take;
  assign in_xfer  = in_valid && in_ready;
  assign wr_xfer  = in_xfer && (in_operation == OP_WRITE);
  assign lk_xfer  = in_xfer && (in_operation == OP_LOOKUP);

  assign wr_in_range = 32'(in_word_addr) < STORE_WORDS;

  // cell = y*256 + z*16 + x; bit position = cell * field width
  assign cell_num  = {in_cell_y, in_cell_z, in_cell_x};
  assign pos       = POS_W'(cell_num) * POS_W'(cfg.field_width);
  assign word      = pos[POS_W-1:6];
  assign word_next = (WORD_W+1)'(word) + (WORD_W+1)'(1);

  assign lo_ok = (32'(word) < 32'(cfg.loaded_words)) && (32'(word) < STORE_WORDS);
  assign hi_ok = (32'(word_next) < 32'(cfg.loaded_words)) && (32'(word_next) < STORE_WORDS);

  assign rd_addr0 = lo_ok ? word[STORE_AW-1:0] : '0;
  assign rd_addr1 = hi_ok ? word_next[STORE_AW-1:0] : '0;

  assign s0_info.off   = pos[5:0];
  assign s0_info.width = cfg.field_width;
  assign s0_info.empty = (cfg.palette_entries == '0) || !lo_ok;
  assign s0_info.hi_ok = hi_ok;

  pie_store u_store (
    .clk      (clk),
    .wr_en    (wr_xfer && wr_in_range),
    .wr_addr  (in_word_addr[STORE_AW-1:0]),
    .wr_data  (in_word_value),
    .rd_en    (lk_xfer),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (word_lo),
    .rd_data1 (word_hi)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (lk_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_xfer) begin
      s1_r <= s0_info;
    end
  end

  pie_extract u_extract (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid_r),
    .s1_info           (s1_r),
    .word_lo           (word_lo),
    .word_hi           (word_hi),
    .palette_entries   (cfg.palette_entries),
    .s1_take           (s1_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_palette_index (out_palette_index),
    .out_is_empty      (out_is_empty)
  );

endmodule
